/* rtl/core/gld_pkg.sv */
// package for the gif lzw decoder: widths, status codes, interlace tables
// no dependencies
package gld_pkg;
    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_NEED    = 3'd1;
    localparam logic [2:0] ST_TAKEN   = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_END     = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_BAD     = 3'd6;
    localparam logic [2:0] ST_FULL    = 3'd7;
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;
    localparam logic [1:0] REG_MIN    = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_INTER  = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] stream_byte;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  pixel_index;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic        last_pixel;
    } t_out_beat;

    function automatic logic [3:0] pass_step(input logic [1:0] p);
        case (p)
            2'd0: pass_step = 4'd8;
            2'd1: pass_step = 4'd8;
            2'd2: pass_step = 4'd4;
            default: pass_step = 4'd2;
        endcase
    endfunction

    function automatic logic [2:0] pass_first(input logic [1:0] p);
        case (p)
            2'd0: pass_first = 3'd0;
            2'd1: pass_first = 3'd4;
            2'd2: pass_first = 3'd2;
            default: pass_first = 3'd1;
        endcase
    endfunction
endpackage

/* rtl/core/gld_if.sv */
// valid/ready channel interfaces for the decoder input and output beats
// depends on gld_pkg
interface gld_in_if;
    import gld_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gld_out_if;
    import gld_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/gld_raster.sv */
// pixel coordinate tracker: column, row, interlace pass, frame end
// depends on gld_pkg
module gld_raster (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic        i_step,
    input  logic [15:0] i_w,
    input  logic [15:0] i_h,
    input  logic        i_interlaced,
    output logic [15:0] o_x,
    output logic [15:0] o_y,
    output logic        o_last
);
    import gld_pkg::*;
    logic [15:0] r_col, r_row, r_done;
    logic [1:0]  r_pass;
    logic [16:0] col_inc, done_inc, row_add;
    logic [15:0] f1, f2, f3;
    logic [15:0] n_row;
    logic [1:0]  n_pass;

    assign col_inc  = {1'b0, r_col} + 17'd1;
    assign done_inc = {1'b0, r_done} + 17'd1;
    assign row_add  = {1'b0, r_row} + {13'd0, pass_step(r_pass)};
    assign o_x    = r_col;
    assign o_y    = r_row;
    assign o_last = (col_inc >= {1'b0, i_w}) && (done_inc >= {1'b0, i_h});
    assign f1 = {13'd0, pass_first(2'd1)};
    assign f2 = {13'd0, pass_first(2'd2)};
    assign f3 = {13'd0, pass_first(2'd3)};

    // skip passes whose first row lies beyond the frame
    always_comb begin
        n_row  = row_add[15:0];
        n_pass = r_pass;
        if (!i_interlaced) begin
            n_row = r_row + 16'd1;
        end else if (row_add >= {1'b0, i_h}) begin
            if (r_pass == 2'd0) begin
                n_pass = 2'd1; n_row = f1;
                if (f1 >= i_h) begin
                    n_pass = 2'd2; n_row = f2;
                    if (f2 >= i_h) begin
                        n_pass = 2'd3; n_row = f3;
                    end
                end
            end else if (r_pass == 2'd1) begin
                n_pass = 2'd2; n_row = f2;
                if (f2 >= i_h) begin
                    n_pass = 2'd3; n_row = f3;
                end
            end else if (r_pass == 2'd2) begin
                n_pass = 2'd3; n_row = f3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0; r_row <= '0; r_done <= '0; r_pass <= '0;
        end else if (i_step) begin
            if (col_inc >= {1'b0, i_w}) begin
                r_col  <= '0;
                r_done <= done_inc[15:0];
                if (done_inc < {1'b0, i_h}) begin
                    r_row  <= n_row;
                    r_pass <= n_pass;
                end
            end else begin
                r_col <= col_inc[15:0];
            end
        end
    end
endmodule

/* rtl/core/gif_lzw_decoder.sv */
// gif lzw decoder top level: apb registers, bit buffer, lzw sequencer with
// prefix/suffix/stack memories. depends on gld_pkg, gld_if, gld_raster
// a push answers with a registered beat; a pull with a pixel stacked passes S_POP and S_OUT,
// on need-byte or a stop at the code answers from S_DEC, else runs S_DEC (again per clear),
// S_WALK per entry, S_POP and S_OUT; one beat in flight: a new beat waits for the result beat
// reset: synchronous active low; any register write restarts the decode; memories undefined
module gif_lzw_decoder #(
    parameter int TABLE_ENTRIES = gld_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    gld_in_if.sink      i_in,
    gld_out_if.source   o_out
);
    import gld_pkg::*;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [12:0] TE = 13'(TABLE_ENTRIES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [3:0]  r_min;
    logic [15:0] r_w, r_h;
    logic        r_int;
    logic        restart;
    logic [3:0]  n_min;

    logic [19:0] r_buf;
    logic [4:0]  r_cnt;
    logic [7:0]  r_left;
    logic [3:0]  r_cw;
    logic [12:0] r_nfc;
    logic [11:0] r_prev;
    logic        r_pv;
    logic [7:0]  r_first;
    logic [12:0] r_sd;
    logic [2:0]  r_stop;
    logic [2:0]  r_state;
    logic [11:0] r_code, r_incode;
    logic        r_ovalid;
    t_out_beat   r_obeat;

    logic [11:0] pfx_mem [TABLE_ENTRIES];
    logic [7:0]  sfx_mem [TABLE_ENTRIES];
    logic [7:0]  stk_mem [TABLE_ENTRIES];
    logic [11:0] r_pfx_q;
    logic [7:0]  r_sfx_q, r_stk_q;
    logic [AW-1:0] walk_addr, stk_raddr, stk_waddr;
    logic        stk_we, tbl_we;
    logic [7:0]  stk_wd;
    logic [12:0] sd_dec;

    logic [3:0]  emin;
    logic [12:0] clear;
    logic [11:0] code;
    logic [11:0] mask;
    logic        raster_step;
    logic [15:0] rx, ry, ew, eh;
    logic        rlast;
    logic [12:0] nfc_inc;

    function automatic t_out_beat status_beat(input logic [2:0] s);
        t_out_beat b;
        b = '0;
        b.status = s;
        return b;
    endfunction

    assign pready  = 1'b1;
    assign restart = psel && penable && pwrite && (paddr[3:2] <= REG_INTER);
    always_comb begin
        case (paddr[3:2])
            REG_MIN:    prdata = {28'd0, r_min};
            REG_WIDTH:  prdata = {16'd0, r_w};
            REG_HEIGHT: prdata = {16'd0, r_h};
            default:    prdata = {31'd0, r_int};
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 4'd8; r_w <= 16'd1; r_h <= 16'd1; r_int <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MIN:    r_min <= pwdata[3:0];
                REG_WIDTH:  r_w   <= pwdata[15:0];
                REG_HEIGHT: r_h   <= pwdata[15:0];
                default:    r_int <= pwdata[0];
            endcase
        end
    end

    // restart takes the code size being written in the same cycle
    assign n_min = (restart && paddr[3:2] == REG_MIN) ? pwdata[3:0] : r_min;
    assign emin  = (n_min < 4'd2) ? 4'd2 : ((n_min > 4'd8) ? 4'd8 : n_min);
    assign clear = 13'd1 << emin;
    assign ew    = (r_w == 16'd0) ? 16'd1 : r_w;
    assign eh    = (r_h == 16'd0) ? 16'd1 : r_h;
    assign mask  = 12'((13'd1 << r_cw) - 13'd1);
    assign code  = r_buf[11:0] & mask;
    assign nfc_inc = r_nfc + 13'd1;
    assign sd_dec  = r_sd - 13'd1;

    gld_raster u_raster (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_restart(restart),
        .i_step(raster_step), .i_w(ew), .i_h(eh), .i_interlaced(r_int),
        .o_x(rx), .o_y(ry), .o_last(rlast)
    );

    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_obeat;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            pfx_mem[r_nfc[AW-1:0]] <= r_prev;
            sfx_mem[r_nfc[AW-1:0]] <= stk_wd;
        end
        r_pfx_q <= pfx_mem[walk_addr];
        r_sfx_q <= sfx_mem[walk_addr];
    end
    always_ff @(posedge i_clk) begin
        if (stk_we) stk_mem[stk_waddr] <= stk_wd;
        r_stk_q <= stk_mem[stk_raddr];
    end

    // the walk reads the entry named by the next code; r_code holds the one read
    logic [11:0] n_code_walk;
    logic        walk_go;
    always_comb begin
        stk_we = 1'b0; tbl_we = 1'b0; stk_wd = 8'd0;
        stk_waddr = r_sd[AW-1:0];
        stk_raddr = sd_dec[AW-1:0];
        walk_addr = r_code[AW-1:0];
        n_code_walk = r_code;
        walk_go = 1'b0;
        raster_step = 1'b0;
        if (r_state == S_WALK) begin
            if (!r_pv) begin
                stk_we = 1'b1; stk_wd = r_code[7:0];
            end else if ({1'b0, r_code} > clear) begin
                if (r_sd < TE) begin
                    stk_we = 1'b1; stk_wd = r_sfx_q;
                end
                n_code_walk = r_pfx_q;
                walk_addr = r_pfx_q[AW-1:0];
                walk_go = 1'b1;
            end else begin
                stk_wd = ({1'b0, r_code} < clear) ? r_code[7:0] : r_sfx_q;
                if (r_nfc < TE) begin
                    stk_we = (r_sd < TE);
                    tbl_we = 1'b1;
                end
            end
        end else if (r_state == S_DEC) begin
            walk_addr = code[AW-1:0];
            if ({1'b0, code} == r_nfc) begin
                walk_addr = r_prev[AW-1:0];
                stk_wd = r_first;
                stk_we = r_pv && (r_cnt >= {1'b0, r_cw});
            end
        end
        if (r_state == S_OUT) raster_step = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_buf <= '0; r_cnt <= '0; r_left <= '0;
            r_cw <= emin + 4'd1; r_nfc <= clear + 13'd2;
            r_prev <= '0; r_pv <= 1'b0; r_first <= '0; r_sd <= '0;
            r_stop <= ST_PIXEL; r_state <= S_IDLE; r_ovalid <= 1'b0;
            r_code <= '0; r_incode <= '0;
        end else begin
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        if (i_in.data.operation == OP_PUSH) begin
                            r_ovalid <= 1'b1;
                            if (r_stop != ST_PIXEL || r_sd != 13'd0 ||
                                r_cnt >= {1'b0, r_cw}) begin
                                r_obeat <= status_beat(ST_REFUSED);
                            end else if (r_left == 8'd0) begin
                                if (i_in.data.stream_byte == 8'd0) begin
                                    r_stop <= ST_EMPTY;
                                    r_obeat <= status_beat(ST_EMPTY);
                                end else begin
                                    r_left <= i_in.data.stream_byte;
                                    r_obeat <= status_beat(ST_TAKEN);
                                end
                            end else begin
                                r_buf <= r_buf | 20'({12'd0, i_in.data.stream_byte} << r_cnt);
                                r_cnt <= r_cnt + 5'd8;
                                r_left <= r_left - 8'd1;
                                r_obeat <= status_beat(ST_TAKEN);
                            end
                        end else if (r_stop != ST_PIXEL) begin
                            r_ovalid <= 1'b1;
                            r_obeat <= status_beat(r_stop);
                        end else if (r_sd != 13'd0) begin
                            r_state <= S_POP;
                        end else begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_DEC: begin
                    if (r_cnt < {1'b0, r_cw}) begin
                        r_obeat <= status_beat(ST_NEED);
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_buf <= r_buf >> r_cw;
                        r_cnt <= r_cnt - {1'b0, r_cw};
                        if ({1'b0, code} == clear + 13'd1) begin
                            r_stop <= ST_END; r_sd <= '0;
                            r_obeat <= status_beat(ST_END);
                            r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else if ({1'b0, code} > r_nfc ||
                                     (!r_pv && {1'b0, code} == r_nfc)) begin
                            r_stop <= ST_BAD; r_sd <= '0;
                            r_obeat <= status_beat(ST_BAD);
                            r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else if ({1'b0, code} == clear) begin
                            r_cw <= emin + 4'd1; r_nfc <= clear + 13'd2; r_pv <= 1'b0;
                        end else if (!r_pv) begin
                            r_first <= code[7:0];
                            r_prev <= code;
                            r_code <= code; r_incode <= code;
                            r_state <= S_WALK;
                        end else begin
                            r_incode <= code;
                            r_code <= ({1'b0, code} == r_nfc) ? r_prev : code;
                            if ({1'b0, code} == r_nfc) r_sd <= r_sd + 13'd1;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (!r_pv) begin
                        r_pv <= 1'b1;
                        r_sd <= r_sd + 13'd1;
                        r_state <= S_POP;
                    end else if (walk_go) begin
                        if (r_sd >= TE) begin
                            r_stop <= ST_BAD; r_sd <= '0;
                            r_obeat <= status_beat(ST_BAD);
                            r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else begin
                            r_sd <= r_sd + 13'd1;
                            r_code <= n_code_walk;
                        end
                    end else begin
                        r_first <= stk_wd;
                        if (r_nfc >= TE) begin
                            r_stop <= ST_FULL; r_sd <= '0;
                            r_obeat <= status_beat(ST_FULL);
                            r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else begin
                            if (r_sd < TE) r_sd <= r_sd + 13'd1;
                            r_nfc <= nfc_inc;
                            if ((nfc_inc & {1'b0, mask}) == 13'd0 && nfc_inc < TE)
                                r_cw <= r_cw + 4'd1;
                            r_prev <= r_incode;
                            r_state <= S_POP;
                        end
                    end
                end
                S_POP: begin
                    r_sd <= r_sd - 13'd1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_obeat <= '{status: ST_PIXEL, pixel_index: r_stk_q, pixel_x: rx,
                                 pixel_y: ry, last_pixel: rlast};
                    if (rlast) begin
                        r_stop <= ST_END; r_sd <= '0;
                    end
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    property p_no_overrun;
        @(posedge i_clk) disable iff (!i_rst_n) r_ovalid && !o_out.ready |=> r_ovalid;
    endproperty
    a_no_overrun: assert property (p_no_overrun) else $error("beat lost");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd <= TE) else $error("stack overflow");
endmodule

/* dv/lzw_pixel_checker.sv */
// checker for the gif lzw decoder: watches both beat channels and the apb port,
// keeps its own copy of the decoder state and compares every result beat
// depends on gld_pkg and gld_if
`timescale 1ns / 1ps
module lzw_pixel_checker
    import gld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gld_in_if           in_mon,
    gld_out_if          out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    localparam int ENTRIES = 4096;
    localparam logic [3:0] ROW_STEP [4] = '{4'd8, 4'd8, 4'd4, 4'd2};
    localparam logic [2:0] ROW_START [4] = '{3'd0, 3'd4, 3'd2, 3'd1};

    logic [3:0]  min_sz;
    logic [15:0] img_w, img_h;
    logic        inter;

    logic [11:0] tbl_prefix [ENTRIES];
    logic [7:0]  tbl_suffix [ENTRIES];
    logic [7:0]  pix_stack [ENTRIES];
    logic [19:0] bitbuf;
    logic [4:0]  bitcnt;
    logic [7:0]  blk_left;
    logic [3:0]  cw;
    logic [12:0] nfree;
    logic [11:0] prev_code;
    logic        prev_ok;
    logic [7:0]  first_sym;
    logic [12:0] depth;
    logic [15:0] col, row, rows;
    logic [1:0]  ipass;
    logic [2:0]  halt;

    t_out_beat pending_results [$];

    assign o_pending = pending_results.size();

    function automatic logic [3:0] eff_min();
        if (min_sz < 4'd2) return 4'd2;
        if (min_sz > 4'd8) return 4'd8;
        return min_sz;
    endfunction

    function automatic logic [16:0] eff_w();
        return (img_w == 16'd0) ? 17'd1 : {1'b0, img_w};
    endfunction

    function automatic logic [16:0] eff_h();
        return (img_h == 16'd0) ? 17'd1 : {1'b0, img_h};
    endfunction

    task automatic restart_decode();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_prefix[i] = '0;
            tbl_suffix[i] = '0;
            pix_stack[i] = '0;
        end
        bitbuf = '0;
        bitcnt = '0;
        blk_left = '0;
        cw = eff_min() + 4'd1;
        nfree = (13'd1 << eff_min()) + 13'd2;
        prev_code = '0;
        prev_ok = 1'b0;
        first_sym = '0;
        depth = '0;
        col = '0;
        row = '0;
        ipass = '0;
        rows = '0;
        halt = ST_PIXEL;
    endtask

    function automatic logic [7:0] symbol_of(input logic [12:0] code);
        if (code < (13'd1 << eff_min())) return code[7:0];
        return tbl_suffix[code[11:0]];
    endfunction

    task automatic stack_sym(input logic [7:0] s);
        if (depth < ENTRIES) begin
            pix_stack[depth[11:0]] = s;
            depth++;
        end
    endtask

    task automatic decode_codes(output logic [2:0] st);
        logic [12:0] clr, code, in_code;
        logic done;
        clr = 13'd1 << eff_min();
        st = ST_PIXEL;
        done = 1'b0;
        while (!done && depth == 0) begin
            if (bitcnt < cw) begin
                st = ST_NEED;
                done = 1'b1;
            end else begin
                code = 13'(bitbuf & ((20'd1 << cw) - 20'd1));
                bitbuf = bitbuf >> cw;
                bitcnt = bitcnt - cw;
                if (code == clr + 13'd1) begin
                    st = ST_END;
                    done = 1'b1;
                end else if (code > nfree) begin
                    st = ST_BAD;
                    done = 1'b1;
                end else if (code == clr) begin
                    cw = eff_min() + 4'd1;
                    nfree = clr + 13'd2;
                    prev_ok = 1'b0;
                end else if (!prev_ok) begin
                    if (code >= nfree) begin
                        st = ST_BAD;
                        done = 1'b1;
                    end else begin
                        first_sym = symbol_of(code);
                        stack_sym(first_sym);
                        prev_code = code[11:0];
                        prev_ok = 1'b1;
                    end
                end else begin
                    in_code = code;
                    if (code == nfree) begin
                        stack_sym(first_sym);
                        code = {1'b0, prev_code};
                    end
                    while (!done && code > clr) begin
                        if (depth >= ENTRIES) begin
                            st = ST_BAD;
                            done = 1'b1;
                        end else begin
                            stack_sym(tbl_suffix[code[11:0]]);
                            code = {1'b0, tbl_prefix[code[11:0]]};
                        end
                    end
                    if (!done) begin
                        first_sym = symbol_of(code);
                        if (nfree >= ENTRIES) begin
                            st = ST_FULL;
                            done = 1'b1;
                        end else begin
                            stack_sym(first_sym);
                            tbl_prefix[nfree[11:0]] = prev_code;
                            tbl_suffix[nfree[11:0]] = first_sym;
                            nfree++;
                            if ((nfree & ((13'd1 << cw) - 13'd1)) == 0 && nfree < ENTRIES)
                                cw++;
                            prev_code = in_code[11:0];
                        end
                    end
                end
            end
        end
    endtask

    task automatic predict_beat(input t_in_beat b, output t_out_beat r);
        logic [2:0]  st;
        logic [31:0] merged;
        logic [16:0] nxt;
        r = '0;
        if (b.operation == OP_PUSH) begin
            if (halt != ST_PIXEL || depth != 0 || bitcnt >= cw) begin
                r.status = ST_REFUSED;
            end else if (blk_left == 0) begin
                if (b.stream_byte == 8'd0) begin
                    halt = ST_EMPTY;
                    r.status = ST_EMPTY;
                end else begin
                    blk_left = b.stream_byte;
                    r.status = ST_TAKEN;
                end
            end else begin
                merged = {12'd0, bitbuf} | (32'(b.stream_byte) << bitcnt);
                bitbuf = merged[19:0];
                bitcnt = bitcnt + 5'd8;
                blk_left--;
                r.status = ST_TAKEN;
            end
        end else if (halt != ST_PIXEL) begin
            r.status = halt;
        end else begin
            decode_codes(st);
            if (st != ST_PIXEL) begin
                if (st != ST_NEED) begin
                    halt = st;
                    depth = '0;
                end
                r.status = st;
            end else begin
                depth--;
                r.status = ST_PIXEL;
                r.pixel_index = pix_stack[depth[11:0]];
                r.pixel_x = col;
                r.pixel_y = row;
                nxt = {1'b0, col} + 17'd1;
                col = nxt[15:0];
                if (nxt >= eff_w()) begin
                    col = '0;
                    rows++;
                    if ({1'b0, rows} >= eff_h()) begin
                        r.last_pixel = 1'b1;
                        halt = ST_END;
                        depth = '0;
                    end else if (inter) begin
                        nxt = {1'b0, row} + 17'(ROW_STEP[ipass]);
                        while (nxt >= eff_h() && ipass < 2'd3) begin
                            ipass++;
                            nxt = 17'(ROW_START[ipass]);
                        end
                        row = nxt[15:0];
                    end else begin
                        row = row + 16'd1;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat exp_r, got;
        if (!i_rst_n) begin
            min_sz = 4'd8;
            img_w = 16'd1;
            img_h = 16'd1;
            inter = 1'b0;
            restart_decode();
            pending_results.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MIN:    min_sz = pwdata[3:0];
                    REG_WIDTH:  img_w = pwdata[15:0];
                    REG_HEIGHT: img_h = pwdata[15:0];
                    default:    inter = pwdata[0];
                endcase
                restart_decode();
            end
            if (out_mon.valid && out_mon.ready) begin
                got = out_mon.data;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: status %0d", got.status);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.status !== exp_r.status)
                        $error("status exp %0d got %0d", exp_r.status, got.status);
                    if (got.pixel_index !== exp_r.pixel_index)
                        $error("pixel_index exp %0d got %0d", exp_r.pixel_index,
                               got.pixel_index);
                    if (got.pixel_x !== exp_r.pixel_x)
                        $error("pixel_x exp %0d got %0d", exp_r.pixel_x, got.pixel_x);
                    if (got.pixel_y !== exp_r.pixel_y)
                        $error("pixel_y exp %0d got %0d", exp_r.pixel_y, got.pixel_y);
                    if (got.last_pixel !== exp_r.last_pixel)
                        $error("last_pixel exp %0d got %0d", exp_r.last_pixel,
                               got.last_pixel);
                    if (got !== exp_r)
                        o_errors <= o_errors + 1;
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                predict_beat(in_mon.data, exp_r);
                pending_results.push_back(exp_r);
            end
        end
    end
endmodule

/* dv/gif_lzw_decoder_tb.sv */
// testbench top for the gif lzw decoder: builds lzw code streams, feeds them
// beat by beat with random gaps and stalls, and gives the verdict
// depends on gld_pkg, gld_if, gif_lzw_decoder and lzw_pixel_checker
`timescale 1ns / 1ps
module gif_lzw_decoder_tb;
    import gld_pkg::*;

    localparam int IDLE_LIMIT = 40000;
    localparam int RANDOM_BEATS = 800;

    typedef enum int { FIN_CODE, FIN_EMPTY, FIN_BAD, FIN_FULL } t_finish;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending;
    int          beats_sent;
    int          send_idle_pct, recv_idle_pct;
    int          quiet_cycles;
    logic [7:0]  stream_q [$];

    gld_in_if  in_ch ();
    gld_out_if out_ch ();

    gif_lzw_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzw_pixel_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_beat(input logic op, input logic [7:0] b, output logic [2:0] st);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= '{operation: op, stream_byte: b};
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        in_ch.valid <= 1'b0;
        beats_sent++;
        do
            @(posedge i_clk);
        while (!(out_ch.valid && out_ch.ready));
        st = out_ch.data.status;
    endtask

    // packs a code stream lsb first and splits it into sub-blocks
    task automatic encode_frame(input logic [3:0] msz, input t_finish fin, input int ncodes);
        int unsigned clr, nf, w, acc, nacc, code, lit_pct, blen;
        logic        pv;
        logic [7:0]  raw [$];
        int          n, idx;
        clr = 1 << msz;
        nf = clr + 2;
        w = msz + 1;
        pv = 1'b0;
        acc = 0;
        nacc = 0;
        lit_pct = (fin == FIN_FULL) ? 90 : 50;
        n = 0;
        while ((fin == FIN_FULL) ? (nf < 4096 || n == 0) : (n < ncodes)) begin
            if (fin != FIN_FULL && $urandom_range(0, 39) == 0) begin
                code = clr;
            end else if (!pv) begin
                code = $urandom_range(0, clr - 1);
            end else if ($urandom_range(0, 99) < lit_pct || nf == clr + 2) begin
                code = $urandom_range(0, clr - 1);
            end else if ($urandom_range(0, 2) == 0 && nf < 4096) begin
                code = nf;
            end else begin
                code = $urandom_range(clr + 2, nf - 1);
            end
            acc |= code << nacc;
            nacc += w;
            while (nacc >= 8) begin
                raw.push_back(acc[7:0]);
                acc >>= 8;
                nacc -= 8;
            end
            if (code == clr) begin
                w = msz + 1;
                nf = clr + 2;
                pv = 1'b0;
            end else if (!pv) begin
                pv = 1'b1;
            end else if (nf < 4096) begin
                nf++;
                if ((nf & ((1 << w) - 1)) == 0 && nf < 4096)
                    w++;
            end
            n++;
        end
        if (fin == FIN_FULL) begin
            code = $urandom_range(0, clr - 1);
        end else if (fin == FIN_BAD) begin
            acc |= clr << nacc;
            nacc += w;
            w = msz + 1;
            code = clr + 2;
        end else begin
            code = (fin == FIN_CODE) ? clr + 1 : 0;
        end
        if (fin != FIN_EMPTY) begin
            acc |= code << nacc;
            nacc += w;
        end
        while (nacc > 0) begin
            raw.push_back(acc[7:0]);
            acc >>= 8;
            nacc = (nacc > 8) ? nacc - 8 : 0;
        end
        stream_q.delete();
        idx = 0;
        while (idx < raw.size()) begin
            blen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
            if (blen > raw.size() - idx)
                blen = raw.size() - idx;
            stream_q.push_back(blen[7:0]);
            for (int i = 0; i < blen; i++)
                stream_q.push_back(raw[idx + i]);
            idx += blen;
        end
        stream_q.push_back(8'd0);
    endtask

    task automatic run_frame(input logic [3:0] msz, input logic [15:0] w, input logic [15:0] h,
                             input logic inter, input t_finish fin, input int ncodes);
        logic [3:0] eff;
        logic [2:0] st;
        int         idx;
        logic       stopped;
        apb_write(REG_MIN, {28'd0, msz});
        apb_write(REG_WIDTH, {16'd0, w});
        apb_write(REG_HEIGHT, {16'd0, h});
        apb_write(REG_INTER, {31'd0, inter});
        eff = (msz < 4'd2) ? 4'd2 : (msz > 4'd8) ? 4'd8 : msz;
        encode_frame(eff, fin, ncodes);
        idx = 0;
        stopped = 1'b0;
        while (!stopped) begin
            send_beat(OP_PULL, 8'($urandom), st);
            if (st == ST_NEED) begin
                if (idx < stream_q.size()) begin
                    send_beat(OP_PUSH, stream_q[idx], st);
                    idx++;
                    stopped = (st >= ST_END);
                end else begin
                    stopped = 1'b1;
                end
            end else if (st >= ST_END) begin
                stopped = 1'b1;
            end else if (st == ST_PIXEL && $urandom_range(0, 24) == 0) begin
                send_beat(OP_PUSH, 8'($urandom), st);
                stopped = (st >= ST_END);
            end
        end
        send_beat(OP_PULL, 8'($urandom), st);
        send_beat(OP_PUSH, 8'($urandom), st);
    endtask

    initial begin
        logic [2:0] st;
        t_finish    fin;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        beats_sent = 0;
        send_idle_pct = 22;
        recv_idle_pct = 72;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pull before any byte, then the end-code, empty and bad-code stops and the extremes
        send_beat(OP_PULL, 8'hff, st);
        run_frame(4'd2, 16'd3, 16'd2, 1'b0, FIN_CODE, 4);
        run_frame(4'd8, 16'd4, 16'd11, 1'b1, FIN_EMPTY, 3);
        run_frame(4'd0, 16'd0, 16'd0, 1'b0, FIN_BAD, 2);
        run_frame(4'd15, 16'd65535, 16'd65535, 1'b1, FIN_CODE, 5);
        run_frame(4'd1, 16'd1, 16'd5, 1'b1, FIN_BAD, 6);

        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent > RANDOM_BEATS / 3) begin
                send_idle_pct = 72;
                recv_idle_pct = 22;
            end
            if (beats_sent > 2 * RANDOM_BEATS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            fin = t_finish'($urandom_range(0, 2));
            run_frame(4'($urandom_range(0, 15)), 16'($urandom_range(1, 24)),
                      16'($urandom_range(1, 14)), 1'($urandom), fin,
                      $urandom_range(2, 60));
        end

        while (pending != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
